// ===== src/jsrl_pkg.sv =====
package jsrl_pkg;

    // Fixed field widths
    localparam int ANGLE_BITS    = 16;
    localparam int JOINT_COUNT   = 5;
    localparam int IDX_BITS      = $clog2(JOINT_COUNT);
    localparam int STEP_BITS     = 15;
    localparam int TOL_BITS      = 15;
    localparam int AGE_BITS      = 8;
    localparam int SERVO_BITS    = 9;
    localparam int FRAC_BITS     = 6;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 15;
    localparam int CNT_BITS      = $clog2(STEP_BITS);

    // Servo mapping, whole degrees
    localparam int SERVO_LO     = 88;
    localparam int SERVO_HI     = 268;
    localparam int SERVO_OFFSET = 178;

    // Register reset values
    localparam logic [STEP_BITS-1:0] STEP_LIMIT_RST  = STEP_BITS'(96);
    localparam logic [TOL_BITS-1:0]  REACH_TOL_RST   = TOL_BITS'(32);
    localparam logic [TOL_BITS-1:0]  ARRIVAL_TOL_RST = TOL_BITS'(128);
    localparam logic [AGE_BITS-1:0]  STALE_RST       = AGE_BITS'(100);
    localparam logic [AGE_BITS-1:0]  AGE_MAX         = '1;

    typedef logic signed [ANGLE_BITS-1:0] t_angle;
    typedef logic [ANGLE_BITS-1:0]        t_mag;
    typedef logic [IDX_BITS-1:0]          t_idx;

    localparam t_angle POS_J2 = t_angle'(190 * 64);
    localparam t_angle POS_J3 = t_angle'(-140 * 64);
    localparam t_angle POS_J4 = t_angle'(-50 * 64);
    localparam t_idx   LAST_IDX = t_idx'(JOINT_COUNT - 1);

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_TARGET   = 2'd1,
        OP_FEEDBACK = 2'd2,
        OP_NONE     = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_STEP_LIMIT  = 2'd0,
        CFG_REACH_TOL   = 2'd1,
        CFG_ARRIVAL_TOL = 2'd2,
        CFG_STALE_TICKS = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MUL,
        S_DIV,
        S_WRITE,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic tgt_write;
        logic fb_write;
        logic scan_clr;
        logic scan_step;
        logic age_inc;
        logic latch_upd;
        logic mul_load;
        logic snap;
        logic div_step;
        logic pos_write;
        logic out_load;
        logic out_cmd_valid;
        t_idx idx;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic target_set;
        logic converged;
        logic scale;
    } t_dp_stat;

    // Power-up pose
    function automatic t_angle start_pos(input t_idx idx);
        t_angle v;
        case (idx)
            t_idx'(1): v = POS_J2;
            t_idx'(2): v = POS_J3;
            t_idx'(3): v = POS_J4;
            default:   v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/jsrl_ctrl.sv =====
module jsrl_ctrl
    import jsrl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_opcode  i_opcode,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state                r_state, n_state;
    t_idx                  r_idx, n_idx;
    logic [CNT_BITS-1:0]   r_bit, n_bit;
    logic                  r_move, n_move;
    logic                  r_out_valid, n_out_valid;

    localparam logic [CNT_BITS-1:0] LAST_BIT = CNT_BITS'(STEP_BITS - 1);

    // State and sequencing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_bit       <= '0;
            r_move      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_bit       <= n_bit;
            r_move      <= n_move;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_bit      = r_bit;
        n_move     = r_move;
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        o_in_ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_opcode)
                        OP_TICK: begin
                            o_cmd.scan_clr = 1'b1;
                            n_idx          = '0;
                            n_state        = S_SCAN;
                        end
                        OP_TARGET: begin
                            o_cmd.tgt_write = 1'b1;
                            n_move          = 1'b0;
                            n_state         = S_EMIT;
                        end
                        OP_FEEDBACK: begin
                            o_cmd.fb_write = 1'b1;
                        end
                        OP_NONE: begin
                        end
                    endcase
                end
            end
            // one joint per cycle: largest delta and feedback check
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DECIDE;
                end else begin
                    n_idx = r_idx + t_idx'(1);
                end
            end
            S_DECIDE: begin
                o_cmd.age_inc = 1'b1;
                n_idx         = '0;
                if (!i_stat.target_set) begin
                    n_move  = 1'b0;
                    n_state = S_EMIT;
                end else if (i_stat.converged) begin
                    o_cmd.latch_upd = 1'b1;
                    n_move          = 1'b0;
                    n_state         = S_EMIT;
                end else begin
                    n_move  = 1'b1;
                    n_state = S_MUL;
                end
            end
            // largest delta within the step limit: all joints jump to target, else each goes to the divider
            S_MUL: begin
                if (i_stat.scale) begin
                    o_cmd.mul_load = 1'b1;
                    n_bit          = '0;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.snap = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_state = S_EMIT;
                    end else begin
                        n_idx = r_idx + t_idx'(1);
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_bit == LAST_BIT) begin
                    n_state = S_WRITE;
                end else begin
                    n_bit = r_bit + CNT_BITS'(1);
                end
            end
            S_WRITE: begin
                o_cmd.pos_write = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_EMIT;
                end else begin
                    n_idx   = r_idx + t_idx'(1);
                    n_state = S_MUL;
                end
            end
            // wait for a free output register
            S_EMIT: begin
                o_cmd.out_cmd_valid = r_move;
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output word valid
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/jsrl_dp.sv =====
module jsrl_dp
    import jsrl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    input  t_angle                   i_value [JOINT_COUNT],
    input  logic [JOINT_COUNT-1:0]   i_update_mask,
    input  logic                     i_cfg_we,
    input  t_cfg_idx                 i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                     o_command_valid,
    output t_angle                   o_joint_cmd [4],
    output logic [SERVO_BITS-1:0]    o_servo_code,
    output logic                     o_arrived
);

    localparam int V_BITS = ANGLE_BITS + 2;
    localparam logic signed [V_BITS-1:0] V_OFFSET = V_BITS'(SERVO_OFFSET * 64);
    localparam logic signed [V_BITS-1:0] V_LO     = V_BITS'(SERVO_LO * 64);
    localparam int D_BITS = V_BITS - FRAC_BITS;
    localparam logic [D_BITS-1:0]     D_HI     = D_BITS'(SERVO_HI);
    localparam logic [SERVO_BITS-1:0] CODE_LO  = SERVO_BITS'(SERVO_LO);
    localparam logic [SERVO_BITS-1:0] CODE_HI  = SERVO_BITS'(SERVO_HI);

    // Configuration registers
    logic [STEP_BITS-1:0] r_step_limit;
    logic [TOL_BITS-1:0]  r_reach_tol;
    logic [TOL_BITS-1:0]  r_arrival_tol;
    logic [AGE_BITS-1:0]  r_stale;

    // Pose state
    t_angle               r_cmd_pos  [JOINT_COUNT];
    t_angle               r_tgt_pos  [JOINT_COUNT];
    t_angle               r_meas_pos [JOINT_COUNT];
    logic [JOINT_COUNT-1:0] r_seen;
    logic                 r_fb_seen;
    logic [AGE_BITS-1:0]  r_age;
    logic                 r_target_set;
    logic                 r_latch;

    // Scan and divide working registers
    t_mag                 r_maxd;
    logic                 r_disagree;
    t_mag                 r_rem;
    logic [STEP_BITS-1:0] r_dvd;
    logic [STEP_BITS-1:0] r_quo;
    logic                 r_neg;

    // Output word
    logic                 r_out_cmd_valid;
    t_angle               r_out_joint [4];
    logic [SERVO_BITS-1:0] r_out_servo;
    logic                 r_out_at;

    logic signed [ANGLE_BITS:0] delta;
    logic signed [ANGLE_BITS:0] fb_err;
    t_mag                 abs_delta;
    t_mag                 abs_err;
    logic [ANGLE_BITS+STEP_BITS-1:0] prod;
    logic [ANGLE_BITS:0]  trial;
    logic                 trial_ge;
    t_angle               step;
    logic                 agrees;
    logic signed [V_BITS-1:0] servo_v;
    logic [D_BITS-1:0]    servo_d;
    logic [SERVO_BITS-1:0] servo_code;

    // Delta and feedback error of the selected joint
    always_comb begin
        delta     = {r_tgt_pos[i_cmd.idx][ANGLE_BITS-1], r_tgt_pos[i_cmd.idx]}
                  - {r_cmd_pos[i_cmd.idx][ANGLE_BITS-1], r_cmd_pos[i_cmd.idx]};
        fb_err    = {r_meas_pos[i_cmd.idx][ANGLE_BITS-1], r_meas_pos[i_cmd.idx]}
                  - {r_tgt_pos[i_cmd.idx][ANGLE_BITS-1], r_tgt_pos[i_cmd.idx]};
        abs_delta = delta[ANGLE_BITS] ? t_mag'(-delta) : t_mag'(delta);
        abs_err   = fb_err[ANGLE_BITS] ? t_mag'(-fb_err) : t_mag'(fb_err);
        prod      = abs_delta * r_step_limit;
        trial     = {r_rem, r_dvd[STEP_BITS-1]};
        trial_ge  = trial >= {1'b0, r_maxd};
        step      = r_neg ? -t_angle'(r_quo) : t_angle'(r_quo);
    end

    // Decision status
    always_comb begin
        agrees            = !r_fb_seen || (r_age >= r_stale) || !r_disagree;
        o_stat.target_set = r_target_set;
        o_stat.converged  = r_maxd < t_mag'(r_reach_tol);
        o_stat.scale      = r_maxd > t_mag'(r_step_limit);
    end

    // Joint 5 servo code: truncated degrees plus offset, saturated
    always_comb begin
        servo_v = {{2{r_cmd_pos[LAST_IDX][ANGLE_BITS-1]}}, r_cmd_pos[LAST_IDX]} + V_OFFSET;
        servo_d = servo_v[V_BITS-1:FRAC_BITS];
        if (servo_v < V_LO) begin
            servo_code = CODE_LO;
        end else if (servo_d > D_HI) begin
            servo_code = CODE_HI;
        end else begin
            servo_code = servo_d[SERVO_BITS-1:0];
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit  <= STEP_LIMIT_RST;
            r_reach_tol   <= REACH_TOL_RST;
            r_arrival_tol <= ARRIVAL_TOL_RST;
            r_stale       <= STALE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STEP_LIMIT:  r_step_limit  <= i_cfg_data;
                CFG_REACH_TOL:   r_reach_tol   <= i_cfg_data;
                CFG_ARRIVAL_TOL: r_arrival_tol <= i_cfg_data;
                CFG_STALE_TICKS: r_stale       <= i_cfg_data[AGE_BITS-1:0];
            endcase
        end
    end

    // Joint arrays
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < JOINT_COUNT; j++) begin
                r_cmd_pos[j]  <= start_pos(t_idx'(j));
                r_tgt_pos[j]  <= '0;
                r_meas_pos[j] <= '0;
            end
        end else begin
            for (int j = 0; j < JOINT_COUNT; j++) begin
                if (i_cmd.tgt_write) begin
                    r_tgt_pos[j] <= i_value[j];
                end
                if (i_cmd.fb_write && i_update_mask[j]) begin
                    r_meas_pos[j] <= i_value[j];
                    if (!r_target_set) begin
                        r_cmd_pos[j] <= i_value[j];
                    end
                end
            end
            if (i_cmd.snap) begin
                r_cmd_pos[i_cmd.idx] <= r_tgt_pos[i_cmd.idx];
            end
            if (i_cmd.pos_write) begin
                r_cmd_pos[i_cmd.idx] <= r_cmd_pos[i_cmd.idx] + step;
            end
        end
    end

    // Target, arrival and feedback bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_set <= 1'b0;
            r_latch      <= 1'b1;
            r_seen       <= '0;
            r_fb_seen    <= 1'b0;
            r_age        <= '0;
        end else begin
            if (i_cmd.tgt_write) begin
                r_target_set <= 1'b1;
                r_latch      <= 1'b0;
            end
            if (i_cmd.latch_upd && agrees) begin
                r_latch <= 1'b1;
            end
            if (i_cmd.fb_write && (i_update_mask != '0)) begin
                r_seen    <= r_seen | i_update_mask;
                r_fb_seen <= 1'b1;
                r_age     <= '0;
            end else if (i_cmd.age_inc && (r_age != AGE_MAX)) begin
                r_age <= r_age + AGE_BITS'(1);
            end
        end
    end

    // Scan accumulators and restoring divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clr) begin
            r_maxd     <= '0;
            r_disagree <= 1'b0;
        end else if (i_cmd.scan_step) begin
            if (abs_delta > r_maxd) begin
                r_maxd <= abs_delta;
            end
            if (r_seen[i_cmd.idx] && (abs_err > t_mag'(r_arrival_tol))) begin
                r_disagree <= 1'b1;
            end
        end
        if (i_cmd.mul_load) begin
            // quotient fits STEP_BITS, so the upper part starts below the divisor
            r_rem <= prod[ANGLE_BITS+STEP_BITS-1:STEP_BITS];
            r_dvd <= prod[STEP_BITS-1:0];
            r_quo <= '0;
            r_neg <= delta[ANGLE_BITS];
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? t_mag'(trial - {1'b0, r_maxd}) : t_mag'(trial);
            r_dvd <= {r_dvd[STEP_BITS-2:0], 1'b0};
            r_quo <= {r_quo[STEP_BITS-2:0], trial_ge};
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_cmd_valid <= i_cmd.out_cmd_valid;
            r_out_at        <= !i_cmd.out_cmd_valid && r_latch;
            for (int j = 0; j < 4; j++) begin
                r_out_joint[j] <= i_cmd.out_cmd_valid ? r_cmd_pos[j] : '0;
            end
            r_out_servo <= i_cmd.out_cmd_valid ? servo_code : '0;
        end
    end

    assign o_command_valid = r_out_cmd_valid;
    assign o_joint_cmd     = r_out_joint;
    assign o_servo_code    = r_out_servo;
    assign o_arrived       = r_out_at;

endmodule

// ===== src/joint_space_rate_limiter.sv =====
// Joint-space rate limiter for five joints, angles in signed 1/64-degree units.
// Input channel (i_in_valid / o_in_ready): one word per item; opcode selects a
// tick, a set-target or a joint-feedback word. Feedback and opcode three give no
// result; tick and set-target each give exactly one output word.
// Output channel (o_out_valid / i_out_ready): command_valid, four joint commands,
// joint 5 servo code, arrival flag; joint and servo are zero if command_valid is 0.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 step limit,
// 1 reach tolerance, 2 arrival tolerance, 3 stale tick count. Write only when idle.
// Sequencing: set-target goes via the emit state to the output register, feedback
// is taken while idle, and a tick scans every joint, then decides. A moving tick
// walks the joints one at a time: each goes straight to target or, when scaled,
// gets one multiply, then a 15-bit restoring divider, one quotient bit per cycle.
// One item is in work at a time; a new word is taken once the previous result
// sits in the output register.
// Reset (synchronous, active low) restores the power-up pose, clears target and
// feedback state, sets the arrival latch and loads register defaults.
// A stalled receiver holds the output word; the next result waits in the
// controller until the output register frees up.
module joint_space_rate_limiter
    import jsrl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_opcode,
    input  logic signed [15:0]       i_value_j1,
    input  logic signed [15:0]       i_value_j2,
    input  logic signed [15:0]       i_value_j3,
    input  logic signed [15:0]       i_value_j4,
    input  logic signed [15:0]       i_value_j5,
    input  logic [4:0]               i_update_mask,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_command_valid,
    output logic signed [15:0]       o_joint1_cmd,
    output logic signed [15:0]       o_joint2_cmd,
    output logic signed [15:0]       o_joint3_cmd,
    output logic signed [15:0]       o_joint4_cmd,
    output logic [8:0]               o_servo_code,
    output logic                     o_arrived,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [14:0]              i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    t_angle   value [JOINT_COUNT];
    t_angle   joint_cmd [4];

    assign value[0] = i_value_j1;
    assign value[1] = i_value_j2;
    assign value[2] = i_value_j3;
    assign value[3] = i_value_j4;
    assign value[4] = i_value_j5;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    jsrl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (t_opcode'(i_opcode)),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // Pose state, divider and output word
    jsrl_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_value         (value),
        .i_update_mask   (i_update_mask),
        .i_cfg_we        (i_cfg_valid),
        .i_cfg_index     (t_cfg_idx'(i_cfg_index)),
        .i_cfg_data      (i_cfg_data),
        .o_command_valid (o_command_valid),
        .o_joint_cmd     (joint_cmd),
        .o_servo_code    (o_servo_code),
        .o_arrived       (o_arrived)
    );

    assign o_joint1_cmd = joint_cmd[0];
    assign o_joint2_cmd = joint_cmd[1];
    assign o_joint3_cmd = joint_cmd[2];
    assign o_joint4_cmd = joint_cmd[3];

`ifndef SYNTHESIS
    // a moving result never reports arrival
    a_move_not_arrived: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_command_valid && o_arrived))
        else $error("command word reports arrival");

    // servo code stays in its saturation range
    a_servo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_command_valid) |->
            (o_servo_code >= SERVO_BITS'(SERVO_LO) && o_servo_code <= SERVO_BITS'(SERVO_HI)))
        else $error("servo code out of range");

    // joint 1, joint 4 and servo fields are zero in a word without a command
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_command_valid) |->
            (o_joint1_cmd == '0 && o_joint4_cmd == '0 && o_servo_code == '0))
        else $error("unused command fields not cleared");

    // feedback never produces a word
    a_feedback_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_opcode == OP_FEEDBACK && !o_out_valid) |=> !o_out_valid)
        else $error("feedback produced an output word");
`endif

endmodule
